// ----- design/fcs_pkg.sv -----
`timescale 1ns / 1ps

package fcs_pkg;

  // Fixed field widths of the request and response items.
  localparam int KIND_W   = 3;
  localparam int ID_W     = 4;
  localparam int AMOUNT_W = 16;
  localparam int STATUS_W = 4;
  localparam int TOTAL_W  = 5;
  localparam int COUNT_W  = 16;

  // Configuration port.
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNT = 1'd1;

  localparam logic [REG_W-1:0] MAX_COUNT_RST  = 16'hFFFF;
  localparam logic [REG_W-1:0] INIT_COUNT_RST = 16'h0000;

  typedef enum logic [KIND_W-1:0] {
    K_WAIT     = 3'd0,
    K_WAIT_NB  = 3'd1,
    K_POLL     = 3'd2,
    K_SIGNAL   = 3'd3,
    K_CANCEL   = 3'd4,
    K_TIMEOUT  = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 4'd0,
    ST_QUEUED    = 4'd1,
    ST_AGAIN     = 4'd2,
    ST_BUSY      = 4'd3,
    ST_INVALID   = 4'd4,
    ST_GRANTED   = 4'd5,
    ST_CANCELED  = 4'd6,
    ST_TIMED_OUT = 4'd7,
    ST_DONE      = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_REL,
    S_CAN,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  // One queue entry: who waits and how much it needs.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [AMOUNT_W-1:0] need;
  } entry_t;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     who;
    logic [TOTAL_W-1:0]  cancel_total;
    logic [COUNT_W-1:0]  count_now;
    logic                last;
  } out_item_t;

endpackage

// ----- design/fcs_req_if.sv -----
`timescale 1ns / 1ps

interface fcs_req_if;
  import fcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ID_W-1:0]     waiter;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, output kind, output waiter, output amount, input ready);
  modport sink   (input valid, input kind, input waiter, input amount, output ready);
endinterface

// ----- design/fcs_rsp_if.sv -----
`timescale 1ns / 1ps

interface fcs_rsp_if;
  import fcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     who;
  logic [TOTAL_W-1:0]  cancel_total;
  logic [COUNT_W-1:0]  count_now;
  logic                last;

  modport source (output valid, output status, output who, output cancel_total,
                  output count_now, output last, input ready);
  modport sink   (input valid, input status, input who, input cancel_total,
                  input count_now, input last, output ready);
endinterface

// ----- design/fifo_counting_semaphore_top.sv -----
`timescale 1ns / 1ps

// Counting semaphore with a strict first-in first-out queue of waiters, each
// waiting for its own needed count. Request items arrive on req (wait,
// non-blocking wait, poll, signal, cancel, timeout) and each produces one or
// more response items on rsp, the final one flagged by last. The waiter queue
// is a circular buffer held in one synchronous memory with a registered read;
// the counter, head pointer and occupancy live in flip-flops. The block works
// on one item at a time: req.ready is high only while it is idle, and it stays
// idle-ready even while a finished response still waits in the output
// register. Signal and cancel run a release loop that retires one head entry
// per memory read and needs one more look to find a head that does not fit.
// A timeout visits one queue position per cycle while it searches; a hit at
// the head then grants further heads at one per cycle unless rsp stalls,
// whereas a hit deeper in the queue closes the gap by moving each later entry
// down one slot per cycle.
// Configuration writes (max_count, init_count) reload the counter from
// init_count and leave the queue alone; they are meant for idle periods only.
module fifo_counting_semaphore_top #(
  parameter int WAITERS    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fcs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fcs_pkg::REG_W-1:0]      cfg_data,
  fcs_req_if.sink                        req,
  fcs_rsp_if.source                      rsp
);
  import fcs_pkg::*;

  localparam int IDX_W = $clog2(WAITERS);
  localparam int OCC_W = $clog2(WAITERS + 1);
  // Common width for comparing the counter against 16-bit amounts, with
  // one extra bit so a saturating add never wraps.
  localparam int CW = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;

  // Logical queue position to physical slot: (base + off) mod WAITERS.
  function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
                                            input logic [OCC_W:0]   off);
    logic [OCC_W+1:0] s;
    s = (OCC_W+2)'(base) + (OCC_W+2)'(off);
    if (s >= (OCC_W+2)'(2 * WAITERS)) begin
      s = s - (OCC_W+2)'(2 * WAITERS);
    end else if (s >= (OCC_W+2)'(WAITERS)) begin
      s = s - (OCC_W+2)'(WAITERS);
    end
    return s[IDX_W-1:0];
  endfunction

  // Queue storage. Entries beyond the occupancy are never looked at.
  entry_t            mem [WAITERS];
  entry_t            rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  entry_t            mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  // Control and datapath registers.
  state_t                state, state_next;
  logic [IDX_W-1:0]      hd, hd_next;
  logic [OCC_W-1:0]      occ, occ_next;
  logic [COUNT_BITS-1:0] counter, counter_next;
  logic [REG_W-1:0]      max_count, init_count;
  logic [OCC_W-1:0]      pos, pos_next;
  logic [AMOUNT_W-1:0]   left, left_next;
  logic [OCC_W-1:0]      total, total_next;
  status_t               fin_st, fin_st_next;
  logic [ID_W-1:0]       fin_who, fin_who_next;
  logic                  rel_sig, rel_sig_next;

  // The accepted request item.
  logic [KIND_W-1:0]     it_kind;
  logic [ID_W-1:0]       it_who;
  logic [AMOUNT_W-1:0]   it_amt;

  // Output register.
  logic                  out_valid;
  out_item_t             out_q;
  logic                  out_free;
  logic                  emit;
  out_item_t             emit_item;

  logic                  accept;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_q.status;
  assign rsp.who          = out_q.who;
  assign rsp.cancel_total = out_q.cancel_total;
  assign rsp.count_now    = out_q.count_now;
  assign rsp.last         = out_q.last;

  // Helper values used across states.
  logic [CW-1:0]     cnt_x, amt_x, need_x, sum_x;
  logic [IDX_W-1:0]  hd_inc, tail;
  logic [OCC_W:0]    pos_p1, pos_p2;
  logic              amt_fits, head_fits, cancel_fits;

  always_comb begin
    cnt_x       = CW'(counter);
    amt_x       = CW'(it_amt);
    need_x      = CW'(rd_data.need);
    sum_x       = cnt_x + amt_x;
    hd_inc      = wrap(hd, (OCC_W+1)'(1));
    tail        = wrap(hd, {1'b0, occ});
    pos_p1      = {1'b0, pos} + (OCC_W+1)'(1);
    pos_p2      = {1'b0, pos} + (OCC_W+1)'(2);
    amt_fits    = (amt_x <= cnt_x);
    head_fits   = (occ != '0) && (need_x <= cnt_x);
    cancel_fits = (occ != '0) && (rd_data.need <= left);
  end

  // Next state and datapath control.
  always_comb begin
    state_next   = state;
    hd_next      = hd;
    occ_next     = occ;
    counter_next = counter;
    pos_next     = pos;
    left_next    = left;
    total_next   = total;
    fin_st_next  = fin_st;
    fin_who_next = fin_who;
    rel_sig_next = rel_sig;
    rd_addr      = hd;
    mem_we       = 1'b0;
    mem_wa       = tail;
    mem_wd       = '{id: it_who, need: it_amt};
    emit         = 1'b0;
    emit_item    = '{status: ST_OK, who: '0, cancel_total: '0,
                     count_now: COUNT_W'(counter), last: 1'b0};

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        fin_who_next = it_who;
        state_next   = S_FIN;
        case (it_kind)
          K_WAIT, K_WAIT_NB: begin
            if ((it_kind == K_WAIT_NB) && (occ != '0)) begin
              fin_st_next = ST_BUSY;
            end else if ((occ == '0) && amt_fits) begin
              counter_next = COUNT_BITS'(cnt_x - amt_x);
              fin_st_next  = ST_OK;
            end else if (occ == OCC_W'(WAITERS)) begin
              fin_st_next = ST_AGAIN;
            end else begin
              mem_we      = 1'b1;
              occ_next    = occ + OCC_W'(1);
              fin_st_next = ST_QUEUED;
            end
          end
          K_POLL: begin
            if ((occ == '0) && amt_fits) begin
              counter_next = COUNT_BITS'(cnt_x - amt_x);
              fin_st_next  = ST_OK;
            end else begin
              fin_st_next = ST_AGAIN;
            end
          end
          K_SIGNAL: begin
            counter_next = (sum_x > CW'({COUNT_BITS{1'b1}})) ? '1 : COUNT_BITS'(sum_x);
            rel_sig_next = 1'b1;
            state_next   = S_REL;
          end
          K_CANCEL: begin
            if ((it_amt == '0) || (it_amt >= max_count)) begin
              fin_st_next = ST_INVALID;
            end else begin
              left_next  = it_amt;
              total_next = '0;
              state_next = S_CAN;
            end
          end
          K_TIMEOUT: begin
            pos_next   = '0;
            state_next = S_SCAN;
          end
          default: begin
            fin_st_next = ST_INVALID;
          end
        endcase
      end

      // Grant heads while they fit. After a timeout the previous result is
      // held in fin_* until the next decision tells whether it is the last.
      S_REL: begin
        if (head_fits) begin
          if (out_free) begin
            emit = 1'b1;
            if (rel_sig) begin
              emit_item.status    = ST_GRANTED;
              emit_item.who       = rd_data.id;
              emit_item.count_now = COUNT_W'(COUNT_BITS'(cnt_x - need_x));
            end else begin
              emit_item.status = fin_st;
              emit_item.who    = fin_who;
            end
            fin_st_next  = ST_GRANTED;
            fin_who_next = rd_data.id;
            counter_next = COUNT_BITS'(cnt_x - need_x);
            hd_next      = hd_inc;
            occ_next     = occ - OCC_W'(1);
            rd_addr      = hd_inc;
          end
        end else begin
          if (rel_sig) begin
            fin_st_next  = ST_OK;
            fin_who_next = '0;
          end
          state_next = S_FIN;
        end
      end

      S_CAN: begin
        if (cancel_fits) begin
          if (out_free) begin
            emit             = 1'b1;
            emit_item.status = ST_CANCELED;
            emit_item.who    = rd_data.id;
            left_next        = left - rd_data.need;
            total_next       = total + OCC_W'(1);
            hd_next          = hd_inc;
            occ_next         = occ - OCC_W'(1);
            rd_addr          = hd_inc;
          end
        end else begin
          counter_next = '0;
          fin_st_next  = ST_DONE;
          fin_who_next = '0;
          state_next   = S_FIN;
        end
      end

      // rd_data holds the entry at queue position pos.
      S_SCAN: begin
        if (pos >= occ) begin
          fin_st_next = ST_INVALID;
          state_next  = S_FIN;
        end else if (rd_data.id == it_who) begin
          fin_st_next = ST_TIMED_OUT;
          if (pos == '0) begin
            hd_next      = hd_inc;
            occ_next     = occ - OCC_W'(1);
            rd_addr      = hd_inc;
            rel_sig_next = 1'b0;
            state_next   = S_REL;
          end else begin
            rd_addr    = wrap(hd, pos_p1);
            state_next = S_SHIFT;
          end
        end else begin
          pos_next = OCC_W'(pos_p1);
          rd_addr  = wrap(hd, pos_p1);
        end
      end

      // rd_data holds the entry at pos+1; move it down into pos.
      S_SHIFT: begin
        if (pos_p1 < {1'b0, occ}) begin
          mem_we   = 1'b1;
          mem_wa   = wrap(hd, {1'b0, pos});
          mem_wd   = rd_data;
          rd_addr  = wrap(hd, pos_p2);
          pos_next = OCC_W'(pos_p1);
        end else begin
          occ_next   = occ - OCC_W'(1);
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_item.status       = fin_st;
          emit_item.who          = fin_who;
          emit_item.cancel_total = (fin_st == ST_DONE) ? TOTAL_W'(total) : '0;
          emit_item.last         = 1'b1;
          state_next             = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hd  <= '0;
      occ <= '0;
    end else begin
      hd  <= hd_next;
      occ <= occ_next;
    end
  end

  // Configuration registers and the counter; a write reloads the counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_count  <= MAX_COUNT_RST;
      init_count <= INIT_COUNT_RST;
      counter    <= COUNT_BITS'(INIT_COUNT_RST);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MAX_COUNT: begin
          max_count <= cfg_data;
          counter   <= COUNT_BITS'(init_count);
        end
        REG_INIT_COUNT: begin
          init_count <= cfg_data;
          counter    <= COUNT_BITS'(cfg_data);
        end
        default: begin
          counter <= counter;
        end
      endcase
    end else begin
      counter <= counter_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    left    <= left_next;
    total   <= total_next;
    fin_st  <= fin_st_next;
    fin_who <= fin_who_next;
    rel_sig <= rel_sig_next;
    if (accept) begin
      it_kind <= req.kind;
      it_who  <= req.waiter;
      it_amt  <= req.amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_q <= emit_item;
    end
  end

endmodule

// ----- design/fcs_checker.sv -----
`timescale 1ns / 1ps

module fcs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [fcs_pkg::STATUS_W-1:0] rsp_status,
  input logic [fcs_pkg::ID_W-1:0]     rsp_who,
  input logic [fcs_pkg::TOTAL_W-1:0]  rsp_cancel_total,
  input logic [fcs_pkg::COUNT_W-1:0]  rsp_count_now,
  input logic                         rsp_last
);
  import fcs_pkg::*;

  // A stalled response holds its whole payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_who)
      && $stable(rsp_cancel_total) && $stable(rsp_count_now) && $stable(rsp_last))
    else $error("response changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another item is in progress");

  // Only grants, cancels and timeouts can be followed by more results.
  a_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |->
      (rsp_status == ST_GRANTED) || (rsp_status == ST_CANCELED) ||
      (rsp_status == ST_TIMED_OUT))
    else $error("intermediate result with a final-only status");

  // A cancel's closing result clears the counter and names no waiter.
  a_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_DONE) |->
      rsp_last && (rsp_who == '0) && (rsp_count_now == '0))
    else $error("malformed cancel summary");

  // The canceled total appears on nothing but the cancel summary.
  a_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_DONE) |-> (rsp_cancel_total == '0))
    else $error("cancel total on a non-summary result");

endmodule

bind fifo_counting_semaphore_top fcs_checker u_fcs_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_who          (rsp.who),
  .rsp_cancel_total (rsp.cancel_total),
  .rsp_count_now    (rsp.count_now),
  .rsp_last         (rsp.last)
);
